// ===== rtl/core/phase_sequence_detector_unit_macros.svh =====
// Assertion macros for the phase sequence detector unit.
// Depends on nothing; the including module must have aclk and aresetn.
`ifndef PHASE_SEQUENCE_DETECTOR_UNIT_MACROS_SVH
`define PHASE_SEQUENCE_DETECTOR_UNIT_MACROS_SVH

// Checked on every rising edge of aclk, switched off while reset is held.
`define PSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked on every rising edge of aclk, reset included.
`define PSD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== rtl/core/psd_pkg.sv =====
// Package of the phase sequence detector: codes, constants and the window classifier.
// Used by psd_window, psd_decide and phase_sequence_detector_unit; depends on nothing.
package psd_pkg;

    localparam int CNT_W               = 3;
    localparam int CAPTURES_PER_WINDOW = 6;
    localparam int WIN_W               = 8;
    localparam int RUN_W               = 8;
    localparam int THR_W               = 8;

    localparam logic [THR_W-1:0] MATCH_THRESHOLD_RESET = 8'd5;
    localparam logic [THR_W-1:0] ERROR_THRESHOLD_RESET = 8'd15;
    localparam logic [RUN_W-1:0] RUN_MAX               = 8'hFF;

    // Valid windows for each phase order.
    localparam logic [WIN_W-1:0] POS_WIN_A = 8'h1E;
    localparam logic [WIN_W-1:0] POS_WIN_B = 8'h87;
    localparam logic [WIN_W-1:0] POS_WIN_C = 8'hE1;
    localparam logic [WIN_W-1:0] POS_WIN_D = 8'h78;
    localparam logic [WIN_W-1:0] REV_WIN_A = 8'h2D;
    localparam logic [WIN_W-1:0] REV_WIN_B = 8'hD2;
    localparam logic [WIN_W-1:0] REV_WIN_C = 8'h4B;
    localparam logic [WIN_W-1:0] REV_WIN_D = 8'hB4;

    typedef enum logic {
        MODE_CAPTURE  = 1'b0,
        MODE_EVALUATE = 1'b1
    } mode_t;

    typedef enum logic {
        CFG_MATCH_THRESHOLD = 1'b0,
        CFG_ERROR_THRESHOLD = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_UNKNOWN  = 2'd0,
        STATUS_POSITIVE = 2'd1,
        STATUS_REVERSE  = 2'd2,
        STATUS_LACKING  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CLASS_ERROR    = 2'd0,
        CLASS_POSITIVE = 2'd1,
        CLASS_REVERSE  = 2'd2
    } win_class_t;

    typedef struct packed {
        status_t status;
        logic    direction;
        logic    done;
    } decision_t;

    function automatic win_class_t classify(input logic [WIN_W-1:0] win);
        win_class_t cls;
        case (win)
            POS_WIN_A, POS_WIN_B, POS_WIN_C, POS_WIN_D: cls = CLASS_POSITIVE;
            REV_WIN_A, REV_WIN_B, REV_WIN_C, REV_WIN_D: cls = CLASS_REVERSE;
            default:                                    cls = CLASS_ERROR;
        endcase
        return cls;
    endfunction

    function automatic logic [RUN_W-1:0] sat_inc(input logic [RUN_W-1:0] v);
        logic [RUN_W-1:0] r;
        r = (v == RUN_MAX) ? RUN_MAX : v + 1'b1;
        return r;
    endfunction

endpackage

// ===== rtl/core/psd_window.sv =====
// Sample window of the phase sequence detector: shift register, capture count and ready flag.
// Depends on psd_pkg.
module psd_window (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  psd_pkg::mode_t              mode,
    input  logic [1:0]                  phase_levels,
    output logic [psd_pkg::WIN_W-1:0]   window,
    output logic                        window_ready,
    output logic                        eval_en
);

    logic [psd_pkg::WIN_W-1:0] window_reg, window_next;
    logic [psd_pkg::CNT_W-1:0] count_reg, count_next, count_inc;
    logic                      ready_reg, ready_next;
    logic                      capture_en;

    assign capture_en = step && (mode == psd_pkg::MODE_CAPTURE) && !ready_reg;
    assign eval_en    = step && (mode == psd_pkg::MODE_EVALUATE) && ready_reg;
    assign count_inc  = count_reg + 1'b1;

    always_comb begin
        window_next = window_reg;
        count_next  = count_reg;
        ready_next  = ready_reg;
        if (capture_en) begin
            window_next = {window_reg[psd_pkg::WIN_W-3:0], phase_levels};
            if (count_inc >= psd_pkg::CNT_W'(psd_pkg::CAPTURES_PER_WINDOW)) begin
                count_next = '0;
                ready_next = 1'b1;
            end else begin
                count_next = count_inc;
            end
        end else if (eval_en) begin
            ready_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            count_reg  <= '0;
            ready_reg  <= 1'b0;
        end else begin
            window_reg <= window_next;
            count_reg  <= count_next;
            ready_reg  <= ready_next;
        end
    end

    assign window       = window_reg;
    assign window_ready = ready_reg;

endmodule

// ===== rtl/core/psd_decide.sv =====
// Decision logic of the phase sequence detector: run counters, status, direction and done.
// Depends on psd_pkg.
module psd_decide (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        eval_en,
    input  logic [psd_pkg::WIN_W-1:0]   window,
    input  logic [psd_pkg::THR_W-1:0]   match_threshold,
    input  logic [psd_pkg::THR_W-1:0]   error_threshold,
    output psd_pkg::decision_t          decision
);

    logic [psd_pkg::RUN_W-1:0] pos_run_reg, pos_run_next;
    logic [psd_pkg::RUN_W-1:0] rev_run_reg, rev_run_next;
    logic [psd_pkg::RUN_W-1:0] err_run_reg, err_run_next;
    logic [psd_pkg::RUN_W-1:0] pos_inc, rev_inc, err_inc;
    psd_pkg::decision_t        dec_reg, dec_next;
    psd_pkg::win_class_t       cls;

    assign cls     = psd_pkg::classify(window);
    assign pos_inc = psd_pkg::sat_inc(pos_run_reg);
    assign rev_inc = psd_pkg::sat_inc(rev_run_reg);
    assign err_inc = psd_pkg::sat_inc(err_run_reg);

    always_comb begin
        pos_run_next = pos_run_reg;
        rev_run_next = rev_run_reg;
        err_run_next = err_run_reg;
        dec_next     = dec_reg;
        if (eval_en) begin
            case (cls)
                psd_pkg::CLASS_POSITIVE: begin
                    dec_next.direction = 1'b1;
                    rev_run_next       = '0;
                    err_run_next       = '0;
                    if (pos_inc > match_threshold) begin
                        dec_next.status = psd_pkg::STATUS_POSITIVE;
                        dec_next.done   = 1'b1;
                        pos_run_next    = '0;
                    end else begin
                        pos_run_next = pos_inc;
                    end
                end
                psd_pkg::CLASS_REVERSE: begin
                    dec_next.direction = 1'b0;
                    pos_run_next       = '0;
                    err_run_next       = '0;
                    if (rev_inc > match_threshold) begin
                        dec_next.status = psd_pkg::STATUS_REVERSE;
                        dec_next.done   = 1'b1;
                        rev_run_next    = '0;
                    end else begin
                        rev_run_next = rev_inc;
                    end
                end
                default: begin
                    pos_run_next = '0;
                    rev_run_next = '0;
                    // A zero threshold behaves as one: the first bad window decides.
                    if (err_inc >= error_threshold) begin
                        dec_next.status = psd_pkg::STATUS_LACKING;
                        dec_next.done   = 1'b1;
                        err_run_next    = '0;
                    end else begin
                        err_run_next = err_inc;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_run_reg       <= '0;
            rev_run_reg       <= '0;
            err_run_reg       <= '0;
            dec_reg.status    <= psd_pkg::STATUS_UNKNOWN;
            dec_reg.direction <= 1'b1;
            dec_reg.done      <= 1'b0;
        end else begin
            pos_run_reg <= pos_run_next;
            rev_run_reg <= rev_run_next;
            err_run_reg <= err_run_next;
            dec_reg     <= dec_next;
        end
    end

    assign decision = dec_reg;

endmodule

// ===== rtl/core/phase_sequence_detector_unit.sv =====
// A result passes the input register and then the state registers before it is valid.
// With m_ready high, one transaction per cycle; the state doubles as the result register.
// The input register lets a new transaction in while a result waits on the output.
// Reset (aresetn, synchronous, active low) clears the window, counters and handshakes,
// sets thresholds to 5 and 15, status unknown, direction positive and done low.
`include "phase_sequence_detector_unit_macros.svh"

module phase_sequence_detector_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [1:0]  s_phase_levels,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_direction,
    output logic        m_done_res,
    output logic        m_window_ready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    logic                              in_valid_reg;
    psd_pkg::mode_t                    in_mode_reg;
    logic [1:0]                        in_levels_reg;
    logic                              out_valid_reg;
    logic                              advance;
    logic                              eval_en;
    logic                              window_ready;
    logic [psd_pkg::WIN_W-1:0]         window;
    logic [psd_pkg::THR_W-1:0]         match_thr_reg;
    logic [psd_pkg::THR_W-1:0]         error_thr_reg;
    psd_pkg::decision_t                decision;

    // The held transaction moves into the state when the result slot is free or being freed.
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_mode_reg   <= psd_pkg::mode_t'(s_mode);
            in_levels_reg <= s_phase_levels;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_thr_reg <= psd_pkg::MATCH_THRESHOLD_RESET;
            error_thr_reg <= psd_pkg::ERROR_THRESHOLD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (psd_pkg::cfg_index_t'(cfg_index))
                psd_pkg::CFG_MATCH_THRESHOLD: match_thr_reg <= cfg_data;
                psd_pkg::CFG_ERROR_THRESHOLD: error_thr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    psd_window u_window (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .mode         (in_mode_reg),
        .phase_levels (in_levels_reg),
        .window       (window),
        .window_ready (window_ready),
        .eval_en      (eval_en)
    );

    psd_decide u_decide (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .eval_en         (eval_en),
        .window          (window),
        .match_threshold (match_thr_reg),
        .error_threshold (error_thr_reg),
        .decision        (decision)
    );

    assign m_valid        = out_valid_reg;
    assign m_status       = decision.status;
    assign m_direction    = decision.direction;
    assign m_done_res     = decision.done;
    assign m_window_ready = window_ready;

    `PSD_ASSERT(a_done_sticky, decision.done |=> decision.done, "done flag fell without reset")
    `PSD_ASSERT(a_status_needs_done, (decision.status != psd_pkg::STATUS_UNKNOWN) |-> decision.done, "status decided without done")
    `PSD_ASSERT(a_state_holds, !advance |=> ($stable(decision) && $stable(window_ready) && $stable(window)), "state moved without a transaction")
    `PSD_ASSERT(a_ready_from_capture, (window_ready && !$past(window_ready)) |-> $past(advance && in_mode_reg == psd_pkg::MODE_CAPTURE), "window ready without a capture")
    `PSD_ASSERT_ALWAYS(a_result_waits, (out_valid_reg && !m_ready) |-> !advance, "result overwritten while waiting")

endmodule
